// File: rtl/hhtc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hhtc_pkg
// Types, constants and the angle wrap shared by the heading-hold turn controller.
// ----------------------------------------------------------------------------
package hhtc_pkg;

	// angles in 1/64 degree
	localparam int DEG180 = 11520;
	localparam int DEG360 = 23040;

	localparam logic [13:0] NO_READING    = 14'd9999;
	localparam logic [13:0] STUCK_CM      = 14'd10;
	localparam logic [13:0] RIGHT_OPEN_CM = 14'd50;
	localparam logic [2:0]  APPROACH_TICKS = 3'd5;
	localparam logic [8:0]  STUCK_OFFSET_DEG = 9'd45;
	localparam logic signed [14:0] DONE_TOL = 15'sd64;

	localparam logic [12:0] SERVO_CENTER      = 13'd3000;
	localparam logic [12:0] SERVO_LEFT_STUCK  = 13'd1000;
	localparam logic [12:0] SERVO_RIGHT_STUCK = 13'd5000;
	localparam logic [12:0] SERVO_TURN        = 13'd4000;

	// servo = 2000 + floor((288000 - 125*e) / 288), e = clamped heading error
	localparam logic signed [14:0] ERR_CLAMP  = 15'sd2304;
	localparam logic signed [20:0] SERVO_NUM0 = 21'sd288000;
	localparam logic signed [20:0] SERVO_GAIN = 21'sd125;
	localparam logic [16:0]        RECIP9     = 17'd116509;
	localparam logic [12:0]        SERVO_BASE = 13'd2000;

	localparam logic [1:0] DIR_STRAIGHT = 2'd0;
	localparam logic [1:0] DIR_LEFT     = 2'd1;
	localparam logic [1:0] DIR_RIGHT    = 2'd2;

	typedef enum logic [2:0] {
		REG_TURN_ANGLE    = 3'd0,
		REG_APPROACH_DIST = 3'd1,
		REG_STUCK_TIMEOUT = 3'd2,
		REG_TURN_TIMEOUT  = 3'd3,
		REG_CRUISE_THRUST = 3'd4,
		REG_TURN_THRUST   = 3'd5
	} reg_idx_t;

	typedef enum logic [1:0] {
		SRV_HOLD  = 2'd0,
		SRV_CONST = 2'd1,
		SRV_CALC  = 2'd2
	} srv_kind_t;

	typedef struct packed {
		logic [7:0]  turn_deg;
		logic [8:0]  approach_distance_cm;
		logic [15:0] stuck_timeout_ms;
		logic [15:0] turn_timeout_ms;
		logic [7:0]  cruise_thrust;
		logic [7:0]  turn_thrust;
	} cfg_t;

	// classified tick, front to back
	typedef struct packed {
		logic [31:0]        now_ms;
		logic signed [14:0] yaw;
		logic               front_blocked;
		logic               approach_hit;
		logic               right_valid;
		logic signed [14:0] turn_target;
		logic [1:0]         turn_dir;
	} cls_t;

	function automatic logic signed [14:0] wrap_ang(input logic signed [16:0] a);
		logic signed [16:0] r;
		r = a;
		if (a > 17'sd11520)
			r = a - 17'sd23040;
		else if (a < -17'sd11520)
			r = a + 17'sd23040;
		return r[14:0];
	endfunction

endpackage
`default_nettype wire

// File: rtl/hhtc_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hhtc_front
// Accepts ticks, classifies distances, works out turn targets, two-entry queue.
// ----------------------------------------------------------------------------
module hhtc_front
	import hhtc_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire cfg_t        cfg,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [79:0] s_tdata,
	output logic             q_valid,
	input  wire logic        q_ready,
	output cls_t             q_entry
);

	logic [31:0]        now_ms;
	logic signed [14:0] yaw;
	logic [13:0]        front_cm;
	logic [13:0]        right_cm;
	logic signed [16:0] yaw_x;
	logic signed [16:0] d_norm;
	logic signed [16:0] d_stuck;
	cls_t               cls;

	cls_t       mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       push;
	logic       pop;

	assign now_ms   = s_tdata[31:0];
	assign yaw      = $signed(s_tdata[46:32]);
	assign front_cm = s_tdata[60:47];
	assign right_cm = s_tdata[74:61];

	always_comb begin
		yaw_x   = $signed({{2{yaw[14]}}, yaw});
		d_norm  = $signed({3'b000, cfg.turn_deg, 6'b000000});
		d_stuck = $signed({3'b000, cfg.turn_deg, 6'b000000})
			- $signed({2'b00, STUCK_OFFSET_DEG, 6'b000000});

		cls.now_ms        = now_ms;
		cls.yaw           = yaw;
		cls.front_blocked = front_cm < STUCK_CM;
		cls.approach_hit  = (front_cm < {5'b00000, cfg.approach_distance_cm})
			&& (front_cm > STUCK_CM) && (front_cm != NO_READING);
		cls.right_valid   = right_cm != NO_READING;
		if (cls.front_blocked) begin
			if (right_cm >= STUCK_CM) begin
				cls.turn_dir    = DIR_RIGHT;
				cls.turn_target = wrap_ang(yaw_x - d_stuck);
			end else begin
				cls.turn_dir    = DIR_LEFT;
				cls.turn_target = wrap_ang(yaw_x + d_stuck);
			end
		end else begin
			if (right_cm >= RIGHT_OPEN_CM) begin
				cls.turn_dir    = DIR_RIGHT;
				cls.turn_target = wrap_ang(yaw_x - d_norm);
			end else begin
				cls.turn_dir    = DIR_LEFT;
				cls.turn_target = wrap_ang(yaw_x + d_norm);
			end
		end
	end

	assign s_tready = count_q != 2'd2;
	assign push     = s_tvalid && s_tready;
	assign q_valid  = count_q != 2'd0;
	assign pop      = q_valid && q_ready;
	assign q_entry  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= cls;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= ~wr_ptr_q;
			if (pop)
				rd_ptr_q <= ~rd_ptr_q;
			if (push && !pop)
				count_q <= count_q + 2'd1;
			else if (pop && !push)
				count_q <= count_q - 2'd1;
		end
	end

endmodule
`default_nettype wire

// File: rtl/hhtc_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hhtc_back
// Mode and turn state update, servo scaling pipeline and output register.
// ----------------------------------------------------------------------------
module hhtc_back
	import hhtc_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire cfg_t        cfg,
	input  wire logic        q_valid,
	output logic             q_ready,
	input  wire cls_t        q_entry,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0]      m_tdata
);

	// turn state
	logic               mode_q;
	logic [1:0]         dir_q;
	logic               stuck_q;
	logic signed [14:0] held_q;
	logic signed [14:0] target_q;
	logic [31:0]        turn_begin_q;
	logic               blk_timing_q;
	logic [31:0]        blk_since_q;
	logic [2:0]         appr_cnt_q;
	logic [7:0]         thrust_q;

	logic               mode_d;
	logic [1:0]         dir_d;
	logic               stuck_d;
	logic signed [14:0] held_d;
	logic signed [14:0] target_d;
	logic [31:0]        turn_begin_d;
	logic               blk_timing_d;
	logic [31:0]        blk_since_d;
	logic [2:0]         appr_cnt_d;
	logic [7:0]         thrust_d;
	srv_kind_t          kind_d;
	logic [12:0]        srv_const_d;

	logic signed [14:0] err;
	logic signed [14:0] err_c;
	logic signed [14:0] rem;
	logic               turn_done;
	logic               start_turn;
	logic [2:0]         cnt_inc;

	// stage 1
	logic               v_s1;
	srv_kind_t          kind_s1;
	logic [12:0]        srv_const_s1;
	logic signed [12:0] err_s1;
	logic [7:0]         thrust_s1;
	logic               mode_s1;
	logic [1:0]         dir_s1;
	logic               stuck_s1;

	// stage 2
	logic               v_s2;
	srv_kind_t          kind_s2;
	logic [12:0]        srv_const_s2;
	logic [14:0]        num_s2;
	logic [7:0]         thrust_s2;
	logic               mode_s2;
	logic [1:0]         dir_s2;
	logic               stuck_s2;
	logic signed [20:0] num_full;

	// output register
	logic        out_valid_q;
	logic [12:0] servo_q;
	logic [7:0]  thrust_out_q;
	logic        mode_out_q;
	logic [1:0]  dir_out_q;
	logic        stuck_out_q;
	logic [31:0] prod;
	logic [12:0] servo_calc;

	logic rdy_out;
	logic rdy_s2;
	logic rdy_s1;
	logic take;

	assign rdy_out = !out_valid_q || m_tready;
	assign rdy_s2  = !v_s2 || rdy_out;
	assign rdy_s1  = !v_s1 || rdy_s2;
	assign q_ready = rdy_s1;
	assign take    = q_valid && rdy_s1;

	always_comb begin
		err = wrap_ang($signed({{2{held_q[14]}}, held_q})
			- $signed({{2{q_entry.yaw[14]}}, q_entry.yaw}));
		if (err > ERR_CLAMP)
			err_c = ERR_CLAMP;
		else if (err < -ERR_CLAMP)
			err_c = -ERR_CLAMP;
		else
			err_c = err;
		rem = wrap_ang($signed({{2{target_q[14]}}, target_q})
			- $signed({{2{q_entry.yaw[14]}}, q_entry.yaw}));

		mode_d       = mode_q;
		dir_d        = dir_q;
		stuck_d      = stuck_q;
		held_d       = held_q;
		target_d     = target_q;
		turn_begin_d = turn_begin_q;
		blk_timing_d = blk_timing_q;
		blk_since_d  = blk_since_q;
		appr_cnt_d   = appr_cnt_q;
		thrust_d     = thrust_q;
		kind_d       = SRV_HOLD;
		srv_const_d  = SERVO_CENTER;
		start_turn   = 1'b0;
		turn_done    = 1'b0;
		cnt_inc      = (appr_cnt_q < APPROACH_TICKS) ? appr_cnt_q + 3'd1 : appr_cnt_q;

		if (!mode_q) begin
			thrust_d = cfg.cruise_thrust;
			kind_d   = SRV_CALC;
			if (q_entry.front_blocked) begin
				if (!blk_timing_q) begin
					blk_timing_d = 1'b1;
					blk_since_d  = q_entry.now_ms;
				end else if ((q_entry.now_ms - blk_since_q)
						>= {16'h0000, cfg.stuck_timeout_ms}) begin
					stuck_d      = 1'b1;
					blk_timing_d = 1'b0;
					start_turn   = q_entry.right_valid;
				end
			end else begin
				blk_timing_d = 1'b0;
			end
			if (q_entry.approach_hit) begin
				appr_cnt_d = cnt_inc;
				if (cnt_inc >= APPROACH_TICKS && q_entry.right_valid)
					start_turn = 1'b1;
			end
			if (start_turn) begin
				held_d       = q_entry.yaw;
				target_d     = q_entry.turn_target;
				mode_d       = 1'b1;
				dir_d        = q_entry.turn_dir;
				turn_begin_d = q_entry.now_ms;
				appr_cnt_d   = 3'd0;
			end
		end else begin
			turn_done = ((rem <= DONE_TOL) && (rem >= -DONE_TOL))
				|| ((q_entry.now_ms - turn_begin_q) > {16'h0000, cfg.turn_timeout_ms});
			if (turn_done) begin
				kind_d      = SRV_CONST;
				srv_const_d = SERVO_CENTER;
				held_d      = q_entry.yaw;
				dir_d       = DIR_STRAIGHT;
				mode_d      = 1'b0;
				stuck_d     = 1'b0;
			end else if (dir_q == DIR_LEFT) begin
				kind_d      = SRV_CONST;
				srv_const_d = stuck_q ? SERVO_LEFT_STUCK : SERVO_TURN;
				thrust_d    = cfg.turn_thrust;
			end else if (dir_q == DIR_RIGHT) begin
				kind_d      = SRV_CONST;
				srv_const_d = stuck_q ? SERVO_RIGHT_STUCK : SERVO_TURN;
				thrust_d    = cfg.turn_thrust;
			end else begin
				mode_d = 1'b0;
				dir_d  = DIR_STRAIGHT;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= 1'b0;
			dir_q        <= DIR_STRAIGHT;
			stuck_q      <= 1'b0;
			held_q       <= '0;
			target_q     <= '0;
			turn_begin_q <= '0;
			blk_timing_q <= 1'b0;
			blk_since_q  <= '0;
			appr_cnt_q   <= '0;
			thrust_q     <= '0;
		end else if (take) begin
			mode_q       <= mode_d;
			dir_q        <= dir_d;
			stuck_q      <= stuck_d;
			held_q       <= held_d;
			target_q     <= target_d;
			turn_begin_q <= turn_begin_d;
			blk_timing_q <= blk_timing_d;
			blk_since_q  <= blk_since_d;
			appr_cnt_q   <= appr_cnt_d;
			thrust_q     <= thrust_d;
		end
	end

	// stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else if (rdy_s1)
			v_s1 <= q_valid;
	end

	always_ff @(posedge clk) begin
		if (take) begin
			kind_s1      <= kind_d;
			srv_const_s1 <= srv_const_d;
			err_s1       <= err_c[12:0];
			thrust_s1    <= thrust_d;
			mode_s1      <= mode_d;
			dir_s1       <= dir_d;
			stuck_s1     <= stuck_d;
		end
	end

	// stage 2: numerator / 32
	assign num_full = SERVO_NUM0 - $signed({{8{err_s1[12]}}, err_s1}) * SERVO_GAIN;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s2 <= 1'b0;
		else if (rdy_s2)
			v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (v_s1 && rdy_s2) begin
			kind_s2      <= kind_s1;
			srv_const_s2 <= srv_const_s1;
			num_s2       <= num_full[19:5];
			thrust_s2    <= thrust_s1;
			mode_s2      <= mode_s1;
			dir_s2       <= dir_s1;
			stuck_s2     <= stuck_s1;
		end
	end

	// output: divide by 9 through the reciprocal, resolve held servo
	assign prod       = {17'd0, num_s2} * {15'd0, RECIP9};
	assign servo_calc = SERVO_BASE + {1'b0, prod[31:20]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			servo_q      <= SERVO_CENTER;
			thrust_out_q <= '0;
			mode_out_q   <= 1'b0;
			dir_out_q    <= DIR_STRAIGHT;
			stuck_out_q  <= 1'b0;
		end else if (rdy_out) begin
			out_valid_q <= v_s2;
			if (v_s2) begin
				case (kind_s2)
					SRV_CALC:  servo_q <= servo_calc;
					SRV_CONST: servo_q <= srv_const_s2;
					default:   servo_q <= servo_q;
				endcase
				thrust_out_q <= thrust_s2;
				mode_out_q   <= mode_s2;
				dir_out_q    <= dir_s2;
				stuck_out_q  <= stuck_s2;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'b0000000, stuck_out_q, dir_out_q, mode_out_q, thrust_out_q, servo_q};

endmodule
`default_nettype wire

// File: rtl/heading_hold_turn_controller.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// heading_hold_turn_controller
// Heading hold in forward mode, stuck and approach turns, servo and thrust out.
// ----------------------------------------------------------------------------
// channel   direction  handshake            payload
// s_*       in         s_tvalid/s_tready    s_tdata: now_ms, yaw_angle, front_cm, right_cm
// m_*       out        m_tvalid/m_tready    m_tdata: servo_ticks, thrust_duty, turning,
//                                                    turn_dir, stuck_flag
// cfg_*     in         cfg_we               cfg_index, cfg_data
//
// One tick per cycle sustained while m_tready is held high; a tick's result beat is registered
// in turn by the queue write, the state update, the scaling and the reciprocal multiply into
// the output register. The state update of the back end is the loop that sets the rate.
// Reset clears the turn state, the queue and the pipeline; servo restarts at 3000.
// Either side may stall: the two-entry queue and per-stage valids absorb it.
// ----------------------------------------------------------------------------
module heading_hold_turn_controller
	import hhtc_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [79:0] s_tdata,   // now_ms[31:0], yaw_angle[46:32], front_cm[60:47],
	                                    // right_cm[74:61]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0]      m_tdata,   // servo_ticks[12:0], thrust_duty[20:13], turning[21],
	                                    // turn_dir[23:22], stuck_flag[24]
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [15:0] cfg_data
);

	cfg_t cfg_q;
	logic q_valid;
	logic q_ready;
	cls_t q_entry;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.turn_deg             <= 8'd60;
			cfg_q.approach_distance_cm <= 9'd40;
			cfg_q.stuck_timeout_ms     <= 16'd2000;
			cfg_q.turn_timeout_ms      <= 16'd3000;
			cfg_q.cruise_thrust        <= 8'd255;
			cfg_q.turn_thrust          <= 8'd200;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_TURN_ANGLE:    cfg_q.turn_deg             <= cfg_data[7:0];
				REG_APPROACH_DIST: cfg_q.approach_distance_cm <= cfg_data[8:0];
				REG_STUCK_TIMEOUT: cfg_q.stuck_timeout_ms     <= cfg_data;
				REG_TURN_TIMEOUT:  cfg_q.turn_timeout_ms      <= cfg_data;
				REG_CRUISE_THRUST: cfg_q.cruise_thrust        <= cfg_data[7:0];
				REG_TURN_THRUST:   cfg_q.turn_thrust          <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	hhtc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.q_valid  (q_valid),
		.q_ready  (q_ready),
		.q_entry  (q_entry)
	);

	hhtc_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.q_valid  (q_valid),
		.q_ready  (q_ready),
		.q_entry  (q_entry),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule
`default_nettype wire
